>>> rtl/assert_macros.svh
// Assertion macros, included by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/tlfs_pkg.sv
// Types and constants of the two-level feedback scheduler.
`default_nettype none
package tlfs_pkg;

  localparam int ID_W    = 16;
  localparam int BURST_W = 32;
  localparam int SLICE_W = 32;

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_SCHEDULE = 1'b1;

  typedef enum logic [1:0] {
    ST_SCHEDULED = 2'd0,
    ST_ADDED     = 2'd1,
    ST_FULL      = 2'd2,
    ST_IDLE      = 2'd3
  } status_t;

  typedef struct packed {
    logic               command;
    logic [ID_W-1:0]    task_id;
    logic [BURST_W-1:0] burst_request;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    granted_id;
    logic [BURST_W-1:0] granted_time;
    logic               task_done;
    logic               from_level;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
  } entry_t;

  // queue control: push at tail, overwrite head, pop head, read head
  typedef struct packed {
    logic push;
    logic head_wr;
    logic pop;
    logic rd;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

>>> rtl/tlfs_fifo.sv
// Circular task queue: entry memory with head pointer and fill count.
`default_nettype none
module tlfs_fifo #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire tlfs_pkg::fifo_ctrl_t ctrl,
  input  wire tlfs_pkg::entry_t     wdata,
  output tlfs_pkg::entry_t          rdata,
  output tlfs_pkg::fifo_stat_t      stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tlfs_pkg::entry_t mem [QUEUE_DEPTH];

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] waddr;

  // head + count stays below twice the depth: one compare and subtract
  always_comb begin
    tail_sum = {1'b0, count} + (CNT_W+1)'(head);
    if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[PTR_W-1:0];
  end

  assign waddr = ctrl.push ? tail : head;

  always_comb begin
    head_next  = head;
    count_next = count;
    if (ctrl.pop) begin
      head_next = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    end
    if (ctrl.push && !ctrl.pop) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop && !ctrl.push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.head_wr) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.rd) begin
      rdata <= mem[head];
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));

endmodule
`default_nettype wire

>>> rtl/two_level_feedback_scheduler.sv
// Top level: command decode, slice arithmetic and the two task queues.
// Add request: result strobe in the cycle after accept; busy stays low, so adds go back to back.
// Schedule request: head entries are read at accept, the grant is computed and written back
//   in the next cycle; the result comes in the cycle after that. busy is high for one cycle, as the
//   queue memories have a registered read, and no new request is taken while it is high.
// Reset: both queues empty, slice_length 1, no result pending; memory contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module two_level_feedback_scheduler #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire tlfs_pkg::req_t           req,
  output logic                          rsp_valid,
  output tlfs_pkg::rsp_t                rsp,
  input  wire                           cfg_we,
  input  wire [tlfs_pkg::SLICE_W-1:0]   cfg_data
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  logic [tlfs_pkg::SLICE_W-1:0] slice_length;

  // accept handshake
  logic accept;
  logic acc_add;
  logic acc_sched;

  // queue interfaces
  tlfs_pkg::fifo_ctrl_t l1_ctrl, l2_ctrl;
  tlfs_pkg::fifo_stat_t l1_stat, l2_stat;
  tlfs_pkg::entry_t     l1_wdata, l2_wdata;
  tlfs_pkg::entry_t     l1_rdata, l2_rdata;

  // decision datapath
  logic                         exec;
  logic                         use_l1;
  logic                         use_l2;
  tlfs_pkg::entry_t             sel;
  logic [tlfs_pkg::SLICE_W-1:0] slice_eff;
  logic [tlfs_pkg::BURST_W-1:0] granted;
  logic [tlfs_pkg::BURST_W-1:0] left;
  logic                         done;

  // result status classes seen by the checks
  logic                         add_reported;
  logic                         idle_reported;

  assign accept    = start && !busy;
  assign acc_add   = accept && (req.command == tlfs_pkg::CMD_ADD);
  assign acc_sched = accept && (req.command == tlfs_pkg::CMD_SCHEDULE);

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length <= tlfs_pkg::SLICE_W'(1);
    end else if (cfg_we) begin
      slice_length <= cfg_data;
    end
  end

  // Queue counts cannot change between accept and the decision cycle,
  // so the flags seen in S_EXEC match the entries read at accept.
  assign exec   = (state == S_EXEC);
  assign use_l1 = exec && !l1_stat.empty;
  assign use_l2 = exec && l1_stat.empty && !l2_stat.empty;
  assign sel    = l1_stat.empty ? l2_rdata : l1_rdata;

  // slice of zero behaves as one
  assign slice_eff = (slice_length == '0) ? tlfs_pkg::SLICE_W'(1) : slice_length;

  always_comb begin
    if ({{(tlfs_pkg::SLICE_W > tlfs_pkg::BURST_W ? tlfs_pkg::SLICE_W - tlfs_pkg::BURST_W
          : 0){1'b0}}, sel.burst} <= slice_eff) begin
      granted = sel.burst;
    end else begin
      granted = tlfs_pkg::BURST_W'(slice_eff);
    end
    left = sel.burst - granted;
    done = (left == '0);
  end

  // Level one: adds push at tail. A scheduled head pops when finished or
  // demoted; if level two is full it stays put with its reduced burst.
  always_comb begin
    l1_ctrl.push    = acc_add && !l1_stat.full;
    l1_ctrl.head_wr = use_l1 && !done && l2_stat.full;
    l1_ctrl.pop     = use_l1 && (done || !l2_stat.full);
    l1_ctrl.rd      = acc_sched;
    l1_wdata        = l1_ctrl.push ? tlfs_pkg::entry_t'{id: req.task_id,
                                                        burst: req.burst_request}
                                   : tlfs_pkg::entry_t'{id: sel.id, burst: left};
  end

  // Level two: demoted tasks push at tail; the served head is rewritten
  // with its remaining burst and pops only when finished (FCFS).
  always_comb begin
    l2_ctrl.push    = use_l1 && !done && !l2_stat.full;
    l2_ctrl.head_wr = use_l2;
    l2_ctrl.pop     = use_l2 && done;
    l2_ctrl.rd      = acc_sched;
    l2_wdata        = tlfs_pkg::entry_t'{id: sel.id, burst: left};
  end

  tlfs_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_level_one (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (l1_ctrl),
    .wdata (l1_wdata),
    .rdata (l1_rdata),
    .stat  (l1_stat)
  );

  tlfs_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_level_two (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (l2_ctrl),
    .wdata (l2_wdata),
    .rdata (l2_rdata),
    .stat  (l2_stat)
  );

  // Sequencer and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc_add) begin
            rsp_valid <= 1'b1;
          end else if (acc_sched) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state     <= S_IDLE;
          busy      <= 1'b0;
          rsp_valid <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (acc_add) begin
      rsp.status       <= l1_stat.full ? tlfs_pkg::ST_FULL : tlfs_pkg::ST_ADDED;
      rsp.granted_id   <= '0;
      rsp.granted_time <= '0;
      rsp.task_done    <= 1'b0;
      rsp.from_level   <= 1'b0;
    end else if (exec) begin
      if (use_l1 || use_l2) begin
        rsp.status       <= tlfs_pkg::ST_SCHEDULED;
        rsp.granted_id   <= sel.id;
        rsp.granted_time <= granted;
        rsp.task_done    <= done;
        rsp.from_level   <= use_l2;
      end else begin
        rsp.status       <= tlfs_pkg::ST_IDLE;
        rsp.granted_id   <= '0;
        rsp.granted_time <= '0;
        rsp.task_done    <= 1'b0;
        rsp.from_level   <= 1'b0;
      end
    end
  end

  assign add_reported  = (rsp.status == tlfs_pkg::ST_ADDED) || (rsp.status == tlfs_pkg::ST_FULL);
  assign idle_reported = rsp_valid && (rsp.status == tlfs_pkg::ST_IDLE);

  // A schedule request keeps busy high for one cycle, holding off the next request; the result comes as busy drops.
  `ASSERT_NEXT(a_sched_busy, clk, rst, acc_sched, busy && !rsp_valid)
  `ASSERT_NEXT(a_exec_one_cycle, clk, rst, busy, !busy && rsp_valid)
  `ASSERT_NEXT(a_add_result, clk, rst, acc_add, rsp_valid && add_reported)
  // Idle is reported only with both queues empty.
  `ASSERT_IMPLIES(a_idle_empty, clk, rst, idle_reported, l1_stat.empty && l2_stat.empty)

endmodule
`default_nettype wire

>>> bench/tlfs_checker.sv
// Grant predictor and result comparison for the two-level feedback scheduler.
module tlfs_checker #(
  parameter int DEPTH = 64
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire                         busy,
  input  tlfs_pkg::req_t              req,
  input  wire                         rsp_valid,
  input  tlfs_pkg::rsp_t              rsp,
  input  wire                         cfg_we,
  input  wire [tlfs_pkg::SLICE_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlfs_pkg::*;

  entry_t               fresh_q [DEPTH];
  entry_t               demoted_q [DEPTH];
  int                   fresh_head, fresh_count;
  int                   demoted_head, demoted_count;
  logic [SLICE_W-1:0]   slice_len;
  rsp_t                 grants_due [$];
  int                   errors = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0t] grant check: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // Applies one request to the shadow queues and returns the result it must produce.
  function automatic rsp_t predict_grant(req_t r);
    rsp_t               o;
    logic [BURST_W-1:0] slice, grant, left;
    int                 slot;
    o = '0;
    slice = (slice_len == '0) ? BURST_W'(1) : slice_len;
    if (r.command == CMD_ADD) begin
      if (fresh_count >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        slot = (fresh_head + fresh_count) % DEPTH;
        fresh_q[slot].id    = r.task_id;
        fresh_q[slot].burst = r.burst_request;
        fresh_count++;
        o.status = ST_ADDED;
      end
    end else if (fresh_count > 0) begin
      grant = (fresh_q[fresh_head].burst <= slice) ? fresh_q[fresh_head].burst : slice;
      left  = fresh_q[fresh_head].burst - grant;
      o.status       = ST_SCHEDULED;
      o.granted_id   = fresh_q[fresh_head].id;
      o.granted_time = grant;
      o.task_done    = (left == '0);
      o.from_level   = 1'b0;
      if (left == '0) begin
        fresh_head = (fresh_head + 1) % DEPTH;
        fresh_count--;
      end else if (demoted_count < DEPTH) begin
        slot = (demoted_head + demoted_count) % DEPTH;
        demoted_q[slot].id    = fresh_q[fresh_head].id;
        demoted_q[slot].burst = left;
        demoted_count++;
        fresh_head = (fresh_head + 1) % DEPTH;
        fresh_count--;
      end else begin
        // second level full: task keeps its place with the reduced burst
        fresh_q[fresh_head].burst = left;
      end
    end else if (demoted_count > 0) begin
      grant = (demoted_q[demoted_head].burst <= slice) ? demoted_q[demoted_head].burst : slice;
      left  = demoted_q[demoted_head].burst - grant;
      o.status       = ST_SCHEDULED;
      o.granted_id   = demoted_q[demoted_head].id;
      o.granted_time = grant;
      o.task_done    = (left == '0);
      o.from_level   = 1'b1;
      demoted_q[demoted_head].burst = left;
      if (left == '0) begin
        demoted_head = (demoted_head + 1) % DEPTH;
        demoted_count--;
      end
    end else begin
      o.status = ST_IDLE;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      fresh_head    = 0;
      fresh_count   = 0;
      demoted_head  = 0;
      demoted_count = 0;
      slice_len     = SLICE_W'(1);
      grants_due.delete();
    end else begin
      if (cfg_we)
        slice_len = cfg_data;
      if (start && !busy)
        grants_due.push_back(predict_grant(req));
      if (rsp_valid) begin
        if (grants_due.size() == 0) begin
          report_mismatch("result with no request pending", 32'(rsp.status), '0);
        end else begin
          want = grants_due.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.granted_id !== want.granted_id)
            report_mismatch("granted_id", 32'(rsp.granted_id), 32'(want.granted_id));
          if (rsp.granted_time !== want.granted_time)
            report_mismatch("granted_time", rsp.granted_time, want.granted_time);
          if (rsp.task_done !== want.task_done)
            report_mismatch("task_done", 32'(rsp.task_done), 32'(want.task_done));
          if (rsp.from_level !== want.from_level)
            report_mismatch("from_level", 32'(rsp.from_level), 32'(want.from_level));
        end
      end
    end
    fail_count  <= errors;
    outstanding <= grants_due.size();
  end

endmodule

>>> bench/tb_two_level_feedback_scheduler.sv
// Stimulus, clock, reset and verdict for the two-level feedback scheduler.
module tb_two_level_feedback_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import tlfs_pkg::*;

  localparam int DEPTH        = 64;
  localparam int STALL_LIMIT  = 2000;  // cycles with no request and no result
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 75;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  req_t               req;
  logic               rsp_valid;
  rsp_t               rsp;
  logic               cfg_we;
  logic [SLICE_W-1:0] cfg_data;

  int fail_count;
  int outstanding;
  int quiet_cycles = 0;
  bit steady;        // no gaps between requests while set
  int add_pct;       // share of add requests in a random phase

  two_level_feedback_scheduler #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Watches both channels and predicts every grant; only the counts come back here.
  tlfs_checker #(
    .DEPTH(DEPTH)
  ) grant_chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result stops the run here.
  always @(posedge clk) begin
    if (rst || (start && !busy) || rsp_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Gap after an accepted request: mostly none or short, now and then long.
  task automatic idle_gap();
    int pick, gap;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55)
      gap = 0;
    else if (pick < 85)
      gap = $urandom_range(1, 3);
    else if (pick < 97)
      gap = $urandom_range(4, 10);
    else
      gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds start until the request is taken. start stays high into the next request
  // when there is no gap, so it is never dropped and raised in one step.
  task automatic issue_request(logic cmd, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
    start <= 1'b1;
    req   <= '{command: cmd, task_id: id, burst_request: burst};
    do @(posedge clk); while (busy);
    idle_gap();
  endtask

  task automatic add_task(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
    issue_request(CMD_ADD, id, burst);
  endtask

  // Schedule requests carry random junk in the ignored fields.
  task automatic schedule_slice();
    issue_request(CMD_SCHEDULE, ID_W'($urandom), $urandom);
  endtask

  // Drops start and waits until every pending result has come out; the write-back ends with the result.
  task automatic settle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_slice(logic [SLICE_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly short bursts so tasks cycle through both levels; some huge ones park in level two.
  function automatic logic [BURST_W-1:0] random_burst();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      return '0;
    else if (pick < 65)
      return BURST_W'($urandom_range(1, 12));
    else if (pick < 88)
      return BURST_W'($urandom_range(1, 200));
    else if (pick < 96)
      return $urandom;
    else
      return '1;
  endfunction

  logic [SLICE_W-1:0] phase_slice [PHASES];

  initial begin
    rst      <= 1'b1;
    start    <= 1'b0;
    req      <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    steady   = 1'b0;
    add_pct  = 50;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: reset slice of 1 ----
    schedule_slice();                       // empty scheduler reports idle
    add_task(16'h0000, 32'h0000_0000);      // zero burst
    add_task(16'hFFFF, 32'hFFFF_FFFF);      // widest id and burst
    add_task(16'h1234, 32'h0000_0001);
    add_task(16'hA5A5, 32'h0000_0003);
    schedule_slice();                       // zero burst: granted 0, done
    schedule_slice();                       // demoted with burst left
    schedule_slice();                       // finishes in one slice
    schedule_slice();                       // demoted
    schedule_slice();                       // level two head, keeps its place
    settle();
    set_slice('0);                          // zero slice behaves as one
    schedule_slice();
    settle();
    set_slice('1);                          // widest slice drains whole bursts
    schedule_slice();
    schedule_slice();
    schedule_slice();                       // idle again
    add_task(16'h8001, 32'h8000_0000);
    schedule_slice();
    settle();

    // ---- both queues full: level-one overflow, then demotion blocked ----
    set_slice(SLICE_W'(1));
    repeat (DEPTH) add_task(ID_W'($urandom), BURST_W'(2));
    add_task(ID_W'($urandom), $urandom);    // dropped, level one full
    repeat (DEPTH) schedule_slice();        // every task demoted, level two now full
    repeat (4) add_task(ID_W'($urandom), BURST_W'(3));
    repeat (12) schedule_slice();           // heads stay in level one until done
    repeat (DEPTH) schedule_slice();        // level two drains in order
    schedule_slice();
    settle();

    // ---- random phases, each at its own slice setting ----
    phase_slice[0] = SLICE_W'(3);
    phase_slice[1] = SLICE_W'(1);
    phase_slice[2] = '1;
    phase_slice[3] = SLICE_W'(2);
    phase_slice[4] = '0;
    phase_slice[5] = SLICE_W'($urandom_range(1, 16));
    phase_slice[6] = SLICE_W'(7);
    phase_slice[7] = $urandom;
    phase_slice[8] = '1;
    for (int p = 0; p < PHASES; p++) begin
      set_slice(phase_slice[p]);
      steady  = (p % 3 == 1);
      add_pct = $urandom_range(30, 70);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < add_pct)
          add_task(ID_W'($urandom), random_burst());
        else
          schedule_slice();
      end
      settle();
    end

    // Stray results after the last one would still be caught here.
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
